FILE: hw/rtl/brcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the buffer release and clock warmth engine.
// Depends on nothing; used by brcw_ctrl, brcw_dp and buffer_release_clock_warmth.
package brcw_pkg;

	// Field widths fixed by the command and result formats.
	localparam int unsigned FRAME_W   = 10;
	localparam int unsigned WARMTH_W  = 8;
	localparam int unsigned REFS_W    = 8;
	localparam int unsigned LIMIT_W   = 11;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 11;

	// Reference count saturates at this value on a pin.
	localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_PIN    = 2'd0,
		CMD_PUT    = 2'd1,
		CMD_WIRE   = 2'd2,
		CMD_UNWIRE = 2'd3
	} cmd_t;

	// Priority hint codes; the remaining codes behave as default.
	localparam logic [2:0] HINT_VERY_LOW  = 3'd0;
	localparam logic [2:0] HINT_LOW       = 3'd1;
	localparam logic [2:0] HINT_HIGH      = 3'd3;
	localparam logic [2:0] HINT_VERY_HIGH = 3'd4;

	// File priority codes; anything else behaves as normal priority.
	localparam logic [1:0] FPRIO_VERY_LOW = 2'd0;
	localparam logic [1:0] FPRIO_LOW      = 2'd1;

	// Result status codes.
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NO_REF = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WARMTH_VERY_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMTH_LOW_CAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMTH_MAX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRTY_BOOST     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIRED_LIMIT     = 3'd4;

	// One frame's metadata word in the frame table.
	typedef struct packed {
		logic                wired;
		logic [WARMTH_W-1:0] warmth;
		logic [REFS_W-1:0]   refs;
	} entry_t;

	// Controller state.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear_we;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} dp_sts_t;

endpackage

FILE: hw/rtl/brcw_ctrl.sv
`timescale 1ns / 1ps
// Controller for the buffer release and clock warmth engine: clearing pass,
// command sequencing and the result valid flag. Depends on brcw_pkg.
module brcw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  brcw_pkg::dp_sts_t    sts,
	output brcw_pkg::ctrl_cmd_t  cmd
);

	brcw_pkg::state_t state_q;
	brcw_pkg::state_t state_nxt;
	logic             out_valid_q;

	// Output decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.clear_we = (state_q == brcw_pkg::ST_CLEAR);
		cmd.accept   = (state_q == brcw_pkg::ST_IDLE) && in_valid;
		cmd.commit   = (state_q == brcw_pkg::ST_EXEC) && (!out_valid_q || !out_stall);
		in_stall     = (state_q != brcw_pkg::ST_IDLE);
	end

	// Next state: sweep the table, then alternate between taking a command
	// and committing it once the result register is free.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			brcw_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = brcw_pkg::ST_IDLE;
				end
			end
			brcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = brcw_pkg::ST_EXEC;
				end
			end
			brcw_pkg::ST_EXEC: begin
				if (cmd.commit) begin
					state_nxt = brcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = brcw_pkg::ST_CLEAR;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brcw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The result register holds a beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/brcw_dp.sv
`timescale 1ns / 1ps
// Datapath for the buffer release and clock warmth engine: frame table,
// configuration registers, warmth update logic and result register.
// Depends on brcw_pkg.
module brcw_dp #(
	parameter int unsigned FRAMES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brcw_pkg::ctrl_cmd_t                 cmd,
	output brcw_pkg::dp_sts_t                   sts,
	input  logic                                cfg_valid,
	input  logic [brcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [brcw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          in_cmd,
	input  logic [brcw_pkg::FRAME_W-1:0]        in_frame,
	input  logic [2:0]                          in_hint,
	input  logic [1:0]                          in_fprio,
	input  logic                                in_dirty,
	input  logic                                in_excl,
	output logic                                status,
	output logic                                is_wired,
	output logic                                dirty_release,
	output logic                                warmth_updated,
	output logic [brcw_pkg::WARMTH_W-1:0]       new_warmth,
	output logic [brcw_pkg::REFS_W-1:0]         new_refs
);

	localparam int unsigned AW    = $clog2(FRAMES);
	localparam int unsigned EXT_W = 17;

	// Frame table, one metadata word per frame.
	brcw_pkg::entry_t mem [FRAMES];
	brcw_pkg::entry_t rd_q;

	// Command fields held for the execute cycle.
	brcw_pkg::cmd_t   cmd_q;
	logic [AW-1:0]    idx_q;
	logic             in_range_q;
	logic [2:0]       hint_q;
	logic [1:0]       fprio_q;
	logic             dirty_q;
	logic             excl_q;

	// Configuration registers.
	logic [brcw_pkg::WARMTH_W-1:0] very_low_q;
	logic [brcw_pkg::WARMTH_W-1:0] low_cap_q;
	logic [brcw_pkg::WARMTH_W-1:0] max_q;
	logic [brcw_pkg::WARMTH_W-1:0] boost_q;
	logic [brcw_pkg::LIMIT_W-1:0]  limit_q;

	logic [brcw_pkg::LIMIT_W-1:0]  wired_total_q;
	logic [AW-1:0]                 clr_addr_q;

	logic [EXT_W-1:0]              frame_ext;
	logic                          in_range;
	logic [AW-1:0]                 idx;

	logic [brcw_pkg::WARMTH_W-1:0] cap_base;
	logic [brcw_pkg::WARMTH_W:0]   boosted;
	logic [brcw_pkg::WARMTH_W-1:0] cap;
	logic [brcw_pkg::WARMTH_W-1:0] climb_w;
	logic [brcw_pkg::REFS_W-1:0]   refs_dec;

	brcw_pkg::entry_t              nxt;
	logic                          status_nxt;
	logic                          written_nxt;
	logic                          updated_nxt;
	logic                          wire_inc;
	logic                          wire_dec;

	// Frame index and range check for the incoming beat.
	assign frame_ext = EXT_W'(in_frame);
	assign in_range  = frame_ext < EXT_W'(FRAMES);
	assign idx       = frame_ext[AW-1:0];

	assign sts.clear_last = (clr_addr_q == AW'(FRAMES - 1));

	// Capture the command fields when a beat is accepted.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q      <= brcw_pkg::cmd_t'(in_cmd);
			idx_q      <= idx;
			in_range_q <= in_range;
			hint_q     <= in_hint;
			fprio_q    <= in_fprio;
			dirty_q    <= in_dirty;
			excl_q     <= in_excl;
		end
	end

	// Frame table: one write port shared by the clearing pass and commits,
	// one registered read port used at accept.
	always_ff @(posedge clk) begin
		if (cmd.clear_we) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.commit && in_range_q) begin
			mem[idx_q] <= nxt;
		end
		if (cmd.accept && in_range) begin
			rd_q <= mem[idx];
		end
	end

	// Clearing pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_we) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			very_low_q <= 8'd0;
			low_cap_q  <= 8'd2;
			max_q      <= 8'd4;
			boost_q    <= 8'd1;
			limit_q    <= 11'd102;
		end else if (cfg_valid) begin
			case (cfg_index)
				brcw_pkg::CFG_WARMTH_VERY_LOW: very_low_q <= cfg_data[7:0];
				brcw_pkg::CFG_WARMTH_LOW_CAP:  low_cap_q  <= cfg_data[7:0];
				brcw_pkg::CFG_WARMTH_MAX:      max_q      <= cfg_data[7:0];
				brcw_pkg::CFG_DIRTY_BOOST:     boost_q    <= cfg_data[7:0];
				brcw_pkg::CFG_WIRED_LIMIT:     limit_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Warmth update: forced low, jump to the ceiling, or a capped one-step
	// climb with an optional dirty boost.
	always_comb begin
		cap_base = ((hint_q == brcw_pkg::HINT_LOW) || (fprio_q == brcw_pkg::FPRIO_LOW))
			? low_cap_q : max_q;
		boosted  = {1'b0, cap_base} + {1'b0, boost_q};
		cap      = (dirty_q && (boosted <= {1'b0, max_q})) ? boosted[7:0] : cap_base;
		if ((hint_q == brcw_pkg::HINT_VERY_LOW) || (fprio_q == brcw_pkg::FPRIO_VERY_LOW)) begin
			climb_w = very_low_q;
		end else if ((hint_q == brcw_pkg::HINT_HIGH) || (hint_q == brcw_pkg::HINT_VERY_HIGH)) begin
			climb_w = (rd_q.warmth < max_q) ? max_q : rd_q.warmth;
		end else begin
			climb_w = (rd_q.warmth < cap) ? (rd_q.warmth + 8'd1) : rd_q.warmth;
		end
	end

	// Command execution on the entry read at accept.
	always_comb begin
		refs_dec    = rd_q.refs - 8'd1;
		nxt         = rd_q;
		status_nxt  = brcw_pkg::STATUS_OK;
		written_nxt = 1'b0;
		updated_nxt = 1'b0;
		wire_inc    = 1'b0;
		wire_dec    = 1'b0;
		case (cmd_q)
			brcw_pkg::CMD_PIN: begin
				if (rd_q.refs != brcw_pkg::REFS_MAX) begin
					nxt.refs = rd_q.refs + 8'd1;
				end
			end
			brcw_pkg::CMD_PUT: begin
				if (rd_q.refs == '0) begin
					status_nxt = brcw_pkg::STATUS_NO_REF;
				end else begin
					written_nxt = excl_q & dirty_q;
					nxt.refs    = refs_dec;
					// Last reference, or last but one on a dirty frame.
					if ((refs_dec == 8'd0) || ((refs_dec == 8'd1) && dirty_q)) begin
						updated_nxt = 1'b1;
						nxt.warmth  = climb_w;
					end
				end
			end
			brcw_pkg::CMD_WIRE: begin
				if (!rd_q.wired && (wired_total_q < limit_q)) begin
					nxt.wired = 1'b1;
					wire_inc  = 1'b1;
				end
			end
			brcw_pkg::CMD_UNWIRE: begin
				if (rd_q.wired) begin
					nxt.wired = 1'b0;
					wire_dec  = (wired_total_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	// Count of wired frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wired_total_q <= '0;
		end else if (cmd.commit && in_range_q) begin
			if (wire_inc) begin
				wired_total_q <= wired_total_q + 11'd1;
			end else if (wire_dec) begin
				wired_total_q <= wired_total_q - 11'd1;
			end
		end
	end

	// Result register; a frame outside the table gives an all-zero beat.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (in_range_q) begin
				status         <= status_nxt;
				is_wired       <= nxt.wired;
				dirty_release  <= written_nxt;
				warmth_updated <= updated_nxt;
				new_warmth     <= nxt.warmth;
				new_refs       <= nxt.refs;
			end else begin
				status         <= brcw_pkg::STATUS_OK;
				is_wired       <= 1'b0;
				dirty_release  <= 1'b0;
				warmth_updated <= 1'b0;
				new_warmth     <= '0;
				new_refs       <= '0;
			end
		end
	end

endmodule

FILE: hw/rtl/buffer_release_clock_warmth.sv
`timescale 1ns / 1ps
// Top level of the buffer release and clock warmth engine.
// Depends on brcw_pkg, brcw_ctrl and brcw_dp.
//
// Usage:
//   The command channel (in_valid / in_stall) carries one command beat:
//   cmd, frame, hint, file_priority, dirty and exclusive. The result
//   channel (out_valid / out_stall) returns exactly one beat per command
//   with status, is_wired, dirty_release, warmth_updated, new_warmth and
//   new_refs. Configuration registers are written through cfg_valid,
//   cfg_ready, cfg_index and cfg_data; cfg_ready is always high.
//   Each command's entry is read from the frame table in the accept
//   cycle and written back when the command commits in the execute state.
//   The result beat is registered at commit, which waits while the
//   previous beat is still stalled, and a new command is not taken
//   until the previous one has committed.
//   After reset the frame table is swept to zero, one frame per cycle;
//   in_stall stays high during the sweep, while configuration writes are
//   taken as usual.
//   When the receiver stalls, the result beat holds in the output register
//   and a new command may still be accepted; it waits to commit until the
//   output register is free.
module buffer_release_clock_warmth #(
	parameter int unsigned FRAMES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [brcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [brcw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [brcw_pkg::FRAME_W-1:0]        frame,
	input  logic [2:0]                          hint,
	input  logic [1:0]                          file_priority,
	input  logic                                dirty,
	input  logic                                exclusive,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic                                is_wired,
	output logic                                dirty_release,
	output logic                                warmth_updated,
	output logic [brcw_pkg::WARMTH_W-1:0]       new_warmth,
	output logic [brcw_pkg::REFS_W-1:0]         new_refs
);

	brcw_pkg::ctrl_cmd_t ctrl_cmd;
	brcw_pkg::dp_sts_t   dp_sts;

	assign cfg_ready = 1'b1;

	brcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (ctrl_cmd)
	);

	brcw_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctrl_cmd),
		.sts            (dp_sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_cmd         (cmd),
		.in_frame       (frame),
		.in_hint        (hint),
		.in_fprio       (file_priority),
		.in_dirty       (dirty),
		.in_excl        (exclusive),
		.status         (status),
		.is_wired       (is_wired),
		.dirty_release  (dirty_release),
		.warmth_updated (warmth_updated),
		.new_warmth     (new_warmth),
		.new_refs       (new_refs)
	);

	// A failed put leaves the frame untouched and reports nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == brcw_pkg::STATUS_NO_REF)) |-> (!warmth_updated && !dirty_release))
	else $error("put with no references reported an update");

	// Warmth is only updated when at most one reference remains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && warmth_updated) |-> ((new_refs == 8'd0) || (new_refs == 8'd1)))
	else $error("warmth updated with references outstanding");

	// An accepted command occupies the engine for its execute cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
	else $error("command accepted on consecutive cycles");

endmodule

FILE: sim/brcw_checker.sv
`timescale 1ns / 1ps
// Checker for the buffer release and clock warmth engine: it mirrors the frame table and
// registers, predicts each result beat and compares it. Depends on brcw_pkg.
module brcw_checker #(
	parameter int unsigned FRAMES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [brcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [brcw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [brcw_pkg::FRAME_W-1:0]        frame,
	input  logic [2:0]                          hint,
	input  logic [1:0]                          file_priority,
	input  logic                                dirty,
	input  logic                                exclusive,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                status,
	input  logic                                is_wired,
	input  logic                                dirty_release,
	input  logic                                warmth_updated,
	input  logic [brcw_pkg::WARMTH_W-1:0]       new_warmth,
	input  logic [brcw_pkg::REFS_W-1:0]         new_refs,
	output int unsigned                         outstanding,
	output int unsigned                         mismatches
);
	import brcw_pkg::*;

	// One result beat as the block should return it.
	typedef struct packed {
		logic                status;
		logic                wired;
		logic                written;
		logic                updated;
		logic [WARMTH_W-1:0] warmth;
		logic [REFS_W-1:0]   refs;
	} release_beat_t;

	// Mirror of the frame table and of the configuration registers.
	logic [REFS_W-1:0]   refs_tbl   [FRAMES];
	logic [WARMTH_W-1:0] warmth_tbl [FRAMES];
	logic                wired_tbl  [FRAMES];
	logic [LIMIT_W-1:0]  wired_count;
	logic [WARMTH_W-1:0] very_low_w, low_cap_w, max_w, boost_w;
	logic [LIMIT_W-1:0]  limit_w;

	release_beat_t beats_due[$];
	int unsigned   mismatch_count = 0;

	assign mismatches = mismatch_count;

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned wanted);
		if (got != wanted)
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, wanted));
	endtask

	// Warmth after a last-reference release, from hint, file priority and dirtiness.
	function automatic logic [WARMTH_W-1:0] climbed_warmth(input logic [WARMTH_W-1:0] w,
		input logic [2:0] h, input logic [1:0] fp, input logic d);
		int unsigned ceiling;
		if (h == HINT_VERY_LOW || fp == FPRIO_VERY_LOW)
			return very_low_w;
		if (h == HINT_HIGH || h == HINT_VERY_HIGH)
			return (w < max_w) ? max_w : w;
		ceiling = (h == HINT_LOW || fp == FPRIO_LOW) ? low_cap_w : max_w;
		if (d && ceiling + boost_w <= max_w)
			ceiling += boost_w;
		if (w < ceiling)
			return w + 1'b1;
		return w;
	endfunction

	// Applies one command to the mirror and queues the beat it should produce.
	task automatic predict_command(input logic [1:0] c, input logic [FRAME_W-1:0] f,
		input logic [2:0] h, input logic [1:0] fp, input logic d, input logic x);
		release_beat_t want;
		logic [REFS_W-1:0] r;
		want = '0;
		if (f < FRAMES) begin
			r = refs_tbl[f];
			case (cmd_t'(c))
				CMD_PIN: begin
					if (r != REFS_MAX)
						refs_tbl[f] = r + 1'b1;
				end
				CMD_PUT: begin
					if (r == '0) begin
						want.status = STATUS_NO_REF;
					end else begin
						want.written = x & d;
						r = r - 1'b1;
						refs_tbl[f] = r;
						// Last reference, or the last but one on a dirty frame.
						if (r == 0 || (r == 1 && d)) begin
							want.updated = 1'b1;
							warmth_tbl[f] = climbed_warmth(warmth_tbl[f], h, fp, d);
						end
					end
				end
				CMD_WIRE: begin
					if (!wired_tbl[f] && wired_count < limit_w) begin
						wired_tbl[f] = 1'b1;
						wired_count = wired_count + 1'b1;
					end
				end
				default: begin
					if (wired_tbl[f]) begin
						wired_tbl[f] = 1'b0;
						if (wired_count != '0)
							wired_count = wired_count - 1'b1;
					end
				end
			endcase
			want.wired  = wired_tbl[f];
			want.warmth = warmth_tbl[f];
			want.refs   = refs_tbl[f];
		end
		beats_due.push_back(want);
	endtask

	// Watches the three channels: register writes, accepted commands and result beats.
	always @(posedge clk or negedge arst_n) begin : watch
		release_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				refs_tbl[i]   = '0;
				warmth_tbl[i] = '0;
				wired_tbl[i]  = 1'b0;
			end
			wired_count = '0;
			very_low_w  = 8'd0;
			low_cap_w   = 8'd2;
			max_w       = 8'd4;
			boost_w     = 8'd1;
			limit_w     = 11'd102;
			beats_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WARMTH_VERY_LOW: very_low_w = cfg_data[WARMTH_W-1:0];
					CFG_WARMTH_LOW_CAP:  low_cap_w  = cfg_data[WARMTH_W-1:0];
					CFG_WARMTH_MAX:      max_w      = cfg_data[WARMTH_W-1:0];
					CFG_DIRTY_BOOST:     boost_w    = cfg_data[WARMTH_W-1:0];
					CFG_WIRED_LIMIT:     limit_w    = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_command(cmd, frame, hint, file_priority, dirty, exclusive);
			if (out_valid && !out_stall) begin
				if (beats_due.size() == 0) begin
					flag_mismatch("result beat with no command waiting");
				end else begin
					want = beats_due.pop_front();
					check_field("status", status, want.status);
					check_field("is_wired", is_wired, want.wired);
					check_field("dirty_release", dirty_release, want.written);
					check_field("warmth_updated", warmth_updated, want.updated);
					check_field("new_warmth", new_warmth, want.warmth);
					check_field("new_refs", new_refs, want.refs);
				end
			end
			outstanding <= beats_due.size();
		end
	end

endmodule

FILE: sim/tb_buffer_release_clock_warmth.sv
`timescale 1ns / 1ps
// Testbench top for buffer_release_clock_warmth: drives commands, register writes and
// result stalls, and gives the verdict. Depends on brcw_pkg and brcw_checker.
module tb_buffer_release_clock_warmth;
	import brcw_pkg::*;

	// Hint and file priority codes that the package leaves unnamed.
	localparam logic [2:0] HINT_DEFAULT   = 3'd2;
	localparam logic [2:0] HINT_UNCHANGED = 3'd5;
	localparam logic [2:0] HINT_SPARE_LO  = 3'd6;
	localparam logic [2:0] HINT_SPARE_HI  = 3'd7;
	localparam logic [1:0] FPRIO_OTHER    = 2'd2;
	localparam logic [1:0] FPRIO_SPARE    = 2'd3;

	// Receiver hold-off that backs the block up into its command input.
	localparam int unsigned HOLD_AT     = 1400;
	localparam int unsigned HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            cmd = '0;
	logic [FRAME_W-1:0]    frame = '0;
	logic [2:0]            hint = '0;
	logic [1:0]            file_priority = '0;
	logic                  dirty = 1'b0;
	logic                  exclusive = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  status;
	logic                  is_wired;
	logic                  dirty_release;
	logic                  warmth_updated;
	logic [WARMTH_W-1:0]   new_warmth;
	logic [REFS_W-1:0]     new_refs;
	int unsigned           outstanding;
	int unsigned           mismatches;

	int unsigned items_sent = 0;
	bit          calm = 1'b0;

	always #5 clk = ~clk;

	buffer_release_clock_warmth u_top (.*);

	brcw_checker u_check (.*);

	// Run limit, far above the slowest correct run.
	initial begin
		#(5_000_000);
		$display("tb_buffer_release_clock_warmth NOT OK");
		$finish;
	end

	// Result side: random stalls, a calm stretch, and one long hold-off.
	initial begin : result_receiver
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 30);
			end
		end
	end

	// Offers one command beat, at times after a random gap, and waits until it is taken.
	task automatic offer(input cmd_t c, input logic [FRAME_W-1:0] f, input logic [2:0] h,
		input logic [1:0] fp, input logic d, input logic x);
		calm = (items_sent >= 700 && items_sent < 950);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		frame         <= f;
		hint          <= h;
		file_priority <= fp;
		dirty         <= d;
		exclusive     <= x;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Register writes keep valid high across the batch and drop it after the last beat.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(input logic [7:0] very_low, input logic [7:0] low_cap,
		input logic [7:0] max, input logic [7:0] boost, input logic [10:0] limit);
		write_reg(CFG_WARMTH_VERY_LOW, {3'b0, very_low});
		write_reg(CFG_WARMTH_LOW_CAP, {3'b0, low_cap});
		write_reg(CFG_WARMTH_MAX, {3'b0, max});
		write_reg(CFG_DIRTY_BOOST, {3'b0, boost});
		write_reg(CFG_WIRED_LIMIT, limit);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering and waits until every result beat is back, then a short pause.
	task automatic drain(input int unsigned extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Mostly a few frames at both ends of the table, so counts and warmth build up.
	function automatic logic [FRAME_W-1:0] pick_frame();
		if ($urandom_range(99) < 70)
			return {($urandom_range(1) != 0) ? 7'h7f : 7'h00, 3'($urandom_range(7))};
		return FRAME_W'($urandom_range(1023));
	endfunction

	// Takes a few references on one frame and releases them, sometimes once too often.
	task automatic pin_then_release();
		logic [FRAME_W-1:0] f;
		logic d;
		int unsigned n;
		f = pick_frame();
		d = 1'($urandom_range(1));
		n = $urandom_range(4, 1);
		repeat (n)
			offer(CMD_PIN, f, 3'($urandom_range(7)), 2'($urandom_range(3)), d,
				1'($urandom_range(1)));
		repeat (n + (($urandom_range(3) == 0) ? 1 : 0))
			offer(CMD_PUT, f, 3'($urandom_range(7)), 2'($urandom_range(3)), d,
				1'($urandom_range(1)));
	endtask

	// Wires and unwires a handful of frames, enough to run into small limits.
	task automatic wire_churn();
		repeat ($urandom_range(6, 1))
			offer(($urandom_range(9) < 7) ? CMD_WIRE : CMD_UNWIRE, pick_frame(),
				3'($urandom_range(7)), 2'($urandom_range(3)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
	endtask

	task automatic run_random(input int unsigned upto);
		int unsigned pick;
		while (items_sent < upto) begin
			pick = $urandom_range(99);
			if (pick < 55)
				pin_then_release();
			else if (pick < 75)
				wire_churn();
			else
				offer(cmd_t'($urandom_range(3)), FRAME_W'($urandom_range(1023)),
					3'($urandom_range(7)), 2'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	initial begin : stimulus
		logic [FRAME_W-1:0] sat_frame;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands under the reset register values.
		offer(CMD_PUT, 10'd0, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PIN, 10'd0, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PIN, 10'd0, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd0, HINT_DEFAULT, FPRIO_OTHER, 1'b1, 1'b1);
		offer(CMD_PUT, 10'd0, HINT_VERY_LOW, FPRIO_OTHER, 1'b0, 1'b1);
		offer(CMD_PIN, 10'd1023, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd1023, HINT_HIGH, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PIN, 10'd1023, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd1023, HINT_VERY_HIGH, FPRIO_LOW, 1'b1, 1'b1);
		offer(CMD_PIN, 10'd1023, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd1023, HINT_LOW, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PIN, 10'd512, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd512, HINT_UNCHANGED, FPRIO_SPARE, 1'b1, 1'b0);
		offer(CMD_PIN, 10'd512, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd512, HINT_SPARE_HI, FPRIO_LOW, 1'b1, 1'b1);
		offer(CMD_PIN, 10'd512, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_PUT, 10'd512, HINT_SPARE_LO, FPRIO_VERY_LOW, 1'b0, 1'b0);
		offer(CMD_WIRE, 10'd5, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_WIRE, 10'd5, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_UNWIRE, 10'd5, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		offer(CMD_UNWIRE, 10'd5, HINT_DEFAULT, FPRIO_OTHER, 1'b0, 1'b0);
		run_random(300);

		// Small ceilings and a wiring limit that the hot frames exceed.
		drain(4);
		apply_config(8'd7, 8'd3, 8'd9, 8'd2, 11'd4);
		run_random(650);

		// Everything at its top value; one frame is pinned past saturation.
		drain(4);
		apply_config(8'd255, 8'd255, 8'd255, 8'd255, 11'd1024);
		sat_frame = FRAME_W'($urandom_range(1023));
		repeat (258)
			offer(CMD_PIN, sat_frame, 3'($urandom_range(7)), 2'($urandom_range(3)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (3)
			offer(CMD_PUT, sat_frame, 3'($urandom_range(7)), 2'($urandom_range(3)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		run_random(1000);

		// Everything at zero: no wiring at all.
		drain(4);
		apply_config(8'd0, 8'd0, 8'd0, 8'd0, 11'd0);
		run_random(1250);

		// A wide ceiling where the dirty boost fits the low cap.
		drain(4);
		apply_config(8'd5, 8'd1, 8'd200, 8'd100, 11'd1);
		run_random(1550);

		// A boost that never fits.
		drain(4);
		apply_config(8'd3, 8'd6, 8'd6, 8'd255, 11'd1023);
		run_random(1800);

		drain(8);
		if (mismatches == 0)
			$display("tb_buffer_release_clock_warmth OK");
		else
			$display("tb_buffer_release_clock_warmth NOT OK");
		$finish;
	end

endmodule

FILE: buffer_release_clock_warmth.f
hw/rtl/brcw_pkg.sv
hw/rtl/brcw_ctrl.sv
hw/rtl/brcw_dp.sv
hw/rtl/buffer_release_clock_warmth.sv
sim/brcw_checker.sv
sim/tb_buffer_release_clock_warmth.sv
